FILE: rtl/rotor_sum_char_cipher_top_assert.svh
// Assertion macros for the rotor sum cipher checker.
// No dependencies; included by rscc_checker.sv.
`ifndef ROTOR_SUM_CHAR_CIPHER_TOP_ASSERT_SVH
`define ROTOR_SUM_CHAR_CIPHER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RSCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rscc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RSCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rscc assertion failed");

`endif

FILE: rtl/rscc_pkg.sv
// Shared types and constants for the rotor sum character cipher.
// No dependencies; used by the top level and its checker.
package rscc_pkg;

	// default geometry
	localparam int DEF_WHEELS = 4;
	localparam int DEF_SLOTS  = 20;

	// field widths
	localparam int CHAR_W   = 8;
	localparam int ENTRY_W  = 7;
	localparam int S_DATA_W = 24;

	// printable range and alphabet size
	localparam logic [7:0] FIRST_PRINT = 8'd32;
	localparam logic [7:0] LAST_PRINT  = 8'd126;
	localparam logic [7:0] SYMBOLS     = 8'd95;

	// operation codes carried on s_tuser
	typedef enum logic [1:0] {
		OP_ENC    = 2'd0,
		OP_DEC    = 2'd1,
		OP_WRITE  = 2'd2,
		OP_SETPOS = 2'd3
	} op_t;

endpackage

FILE: rtl/rscc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rscc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/rotor_sum_char_cipher_top.sv
// Top level of the additive rotor cipher over printable ASCII.
// Depends on rscc_pkg and rscc_ram.
//
// Additive rotor cipher: the key is the sum of every wheel's table entry at
// its position, added mod 95 on encrypt (then the odometer steps forward) or
// subtracted mod 95 on decrypt (after the odometer steps back). A table write
// or a position set leaves the block idle, so it is ready again on the next
// cycle. A character outside 32..126 goes straight to the done state and
// comes back unchanged with bad_char set. An encrypt passes through the sum
// and done states; a decrypt first steps the odometer back in its own state.
// The wheel tables sit in one RAM with a single registered read port, so the
// key sum reads one wheel per cycle through a shared mod-95 accumulator. The
// block takes no new item while a character is in flight; a result waits in
// the output register if the master side stalls. Table contents read as the
// slot index until written, tracked by one valid flop per entry, so there is
// no clearing pass after reset.
module rotor_sum_char_cipher_top #(
	parameter int WHEELS = rscc_pkg::DEF_WHEELS,
	parameter int SLOTS  = rscc_pkg::DEF_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] char_in, [9:8] wheel_sel, [14:10] slot_sel, [21:15] entry_value, [23:22] zero
	input  logic [rscc_pkg::S_DATA_W-1:0] s_tdata,
	// [1:0] op
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] char_out
	output logic [rscc_pkg::CHAR_W-1:0]   m_tdata,
	// [0] bad_char
	output logic                          m_tuser
);

	import rscc_pkg::*;

	localparam int SW    = $clog2(SLOTS);
	localparam int WW    = (WHEELS > 1) ? $clog2(WHEELS) : 1;
	localparam int AW    = WW + SW;
	localparam int DEPTH = 1 << AW;
	localparam int CW    = WW + 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
	localparam logic [CW-1:0] CNT_END   = CW'(WHEELS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_BACK = 4'b0010,
		ST_SUM  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// input beat fields
	logic [CHAR_W-1:0]  char_in;
	logic [1:0]         wheel_sel;
	logic [4:0]         slot_sel;
	logic [ENTRY_W-1:0] entry_value;
	op_t                op;
	logic               s_acc;
	logic               addr_ok;
	logic               char_bad;

	assign char_in     = s_tdata[7:0];
	assign wheel_sel   = s_tdata[9:8];
	assign slot_sel    = s_tdata[14:10];
	assign entry_value = s_tdata[21:15];
	assign op          = op_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign addr_ok  = (int'(wheel_sel) < WHEELS) && (int'(slot_sel) < SLOTS);
	assign char_bad = (char_in < FIRST_PRINT) || (char_in > LAST_PRINT);

	// per-item registers
	op_t               op_q;
	logic [CHAR_W-1:0] char_q;
	logic              bad_q;
	logic [6:0]        acc_q;
	logic [CW-1:0]     cnt_q;

	// wheel positions and table valid flags
	logic [SW-1:0]    pos_q [WHEELS];
	logic [SW-1:0]    pos_fwd [WHEELS];
	logic [SW-1:0]    pos_back [WHEELS];
	logic             fwd_carry;
	logic             back_borrow;
	logic [DEPTH-1:0] vld_q;

	// table RAM ports
	logic               tbl_we;
	logic [AW-1:0]      tbl_waddr;
	logic [AW-1:0]      tbl_raddr;
	logic [ENTRY_W-1:0] tbl_rdata;

	// read pipeline
	logic          rd_issue;
	logic [WW-1:0] rd_wheel;
	logic [SW-1:0] rd_slot;
	logic          rd_vld_s1;
	logic          ent_vld_s1;
	logic [SW-1:0] rd_slot_s1;

	// output register
	logic              m_tvalid_q;
	logic [CHAR_W-1:0] m_tdata_q;
	logic              m_tuser_q;
	logic              out_free;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign out_free = !m_tvalid_q || m_tready;

	// table write on an in-range write beat
	assign tbl_we    = s_acc && (op == OP_WRITE) && addr_ok;
	assign tbl_waddr = {WW'(wheel_sel), SW'(slot_sel)};

	rscc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_tbl (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(entry_value),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	// one wheel read per cycle while summing
	assign rd_issue  = (state_q == ST_SUM) && (cnt_q < CNT_END);
	assign rd_wheel  = rd_issue ? cnt_q[WW-1:0] : '0;
	assign rd_slot   = pos_q[rd_wheel];
	assign tbl_raddr = {rd_wheel, rd_slot};

	// shared mod-95 accumulator
	logic [ENTRY_W-1:0] entry;
	logic [7:0]         ent_mod;
	logic [7:0]         acc_sum;
	logic [7:0]         acc_next;

	always_comb begin
		entry    = ent_vld_s1 ? tbl_rdata : ENTRY_W'(rd_slot_s1);
		ent_mod  = (8'(entry) >= SYMBOLS) ? 8'(entry) - SYMBOLS : 8'(entry);
		acc_sum  = {1'b0, acc_q} + ent_mod;
		acc_next = (acc_sum >= SYMBOLS) ? acc_sum - SYMBOLS : acc_sum;
	end

	// odometer forward and back
	always_comb begin
		pos_fwd   = pos_q;
		pos_back  = pos_q;
		fwd_carry   = 1'b1;
		back_borrow = 1'b1;
		for (int w = 0; w < WHEELS; w++) begin
			if (fwd_carry) begin
				if (pos_q[w] >= LAST_SLOT) begin
					pos_fwd[w] = '0;
				end else begin
					pos_fwd[w] = pos_q[w] + SW'(1);
					fwd_carry  = 1'b0;
				end
			end
			if (back_borrow) begin
				if (pos_q[w] == '0) begin
					pos_back[w] = LAST_SLOT;
				end else begin
					pos_back[w] = pos_q[w] - SW'(1);
					back_borrow = 1'b0;
				end
			end
		end
	end

	// final add or subtract of the key
	logic [6:0]        sym;
	logic [7:0]        enc_sum;
	logic [7:0]        enc_r;
	logic [7:0]        dec_diff;
	logic [7:0]        dec_r;
	logic [6:0]        res_sym;
	logic [CHAR_W-1:0] char_res;

	always_comb begin
		sym      = 7'(char_q - FIRST_PRINT);
		enc_sum  = {1'b0, sym} + {1'b0, acc_q};
		enc_r    = (enc_sum >= SYMBOLS) ? enc_sum - SYMBOLS : enc_sum;
		dec_diff = {1'b0, sym} - {1'b0, acc_q};
		dec_r    = dec_diff[7] ? dec_diff + SYMBOLS : dec_diff;
		res_sym  = (op_q == OP_DEC) ? dec_r[6:0] : enc_r[6:0];
		char_res = bad_q ? char_q : {1'b0, res_sym} + FIRST_PRINT;
	end

	// sequencer, positions, valid flags, output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '{default: '0};
			vld_q      <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						case (op)
							OP_WRITE: begin
								if (addr_ok) begin
									vld_q[tbl_waddr] <= 1'b1;
								end
							end
							OP_SETPOS: begin
								if (addr_ok) begin
									pos_q[WW'(wheel_sel)] <= SW'(slot_sel);
								end
							end
							OP_DEC: begin
								state_q <= char_bad ? ST_DONE : ST_BACK;
							end
							default: begin
								state_q <= char_bad ? ST_DONE : ST_SUM;
							end
						endcase
					end
				end
				ST_BACK: begin
					pos_q   <= pos_back;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (cnt_q == CNT_END) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if ((op_q == OP_ENC) && !bad_q) begin
							pos_q <= pos_fwd;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q   <= op;
			char_q <= char_in;
			bad_q  <= char_bad;
			acc_q  <= '0;
			cnt_q  <= '0;
		end
		if (state_q == ST_SUM) begin
			cnt_q <= cnt_q + CW'(1);
			if (rd_vld_s1) begin
				acc_q <= acc_next[6:0];
			end
		end
		ent_vld_s1 <= vld_q[tbl_raddr];
		rd_slot_s1 <= rd_slot;
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= char_res;
			m_tuser_q <= bad_q;
		end
	end

endmodule

FILE: rtl/rscc_checker.sv
// Port-level checker for the rotor sum character cipher, bound to the top.
// Depends on rscc_pkg and rotor_sum_char_cipher_top_assert.svh.
`include "rotor_sum_char_cipher_top_assert.svh"

module rscc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [1:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser
);

	import rscc_pkg::*;

	logic char_beat;
	logic load_beat;

	assign char_beat = s_tvalid && s_tready && ((s_tuser == OP_ENC) || (s_tuser == OP_DEC));
	assign load_beat = s_tvalid && s_tready &&
		((s_tuser == OP_WRITE) || (s_tuser == OP_SETPOS));

	// a stalled result beat holds
	`RSCC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// a character keeps the block busy for the next cycle
	`RSCC_ASSERT_NEXT(a_char_busy, clk, arst_n, char_beat, !s_tready)

	// table loads and position sets leave the block ready in the next cycle
	`RSCC_ASSERT_NEXT(a_load_ready, clk, arst_n, load_beat, s_tready)

	// flagged characters are outside the printable range
	`RSCC_ASSERT_IMPL(a_bad_range, clk, arst_n, m_tvalid && m_tuser, (m_tdata < FIRST_PRINT) || (m_tdata > LAST_PRINT))

	// cipher output is always printable
	`RSCC_ASSERT_IMPL(a_good_range, clk, arst_n, m_tvalid && !m_tuser, (m_tdata >= FIRST_PRINT) && (m_tdata <= LAST_PRINT))

endmodule

bind rotor_sum_char_cipher_top rscc_checker u_rscc_checker (.*);

FILE: test/rotor_cipher_check.sv
`timescale 1ns / 1ps
// Checker for the rotor sum cipher: tracks wheel tables and positions, predicts each
// output beat and compares it field by field. Depends on rscc_pkg.
module rotor_cipher_check
	import rscc_pkg::*;
#(
	parameter int WHEELS = DEF_WHEELS,
	parameter int SLOTS  = DEF_SLOTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,
	input  logic [1:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [CHAR_W-1:0]    m_tdata,
	input  logic                 m_tuser,
	output int                   errors,
	output int                   pending
);

	typedef struct packed {
		logic [CHAR_W-1:0] text;
		logic              bad;
	} cipher_out_t;

	// shadow copy of the cipher state
	logic [ENTRY_W-1:0] wheel_tab [WHEELS][SLOTS];
	logic [4:0]         wheel_pos [WHEELS];

	cipher_out_t cipher_out_q[$];

	task automatic odometer_fwd();
		logic carry;
		carry = 1'b1;
		for (int w = 0; w < WHEELS; w++) begin
			if (carry) begin
				if (wheel_pos[w] >= 5'(SLOTS - 1)) begin
					wheel_pos[w] = '0;
				end else begin
					wheel_pos[w] = wheel_pos[w] + 5'd1;
					carry = 1'b0;
				end
			end
		end
	endtask

	task automatic odometer_back();
		logic borrow;
		borrow = 1'b1;
		for (int w = 0; w < WHEELS; w++) begin
			if (borrow) begin
				if (wheel_pos[w] == '0) begin
					wheel_pos[w] = 5'(SLOTS - 1);
				end else begin
					wheel_pos[w] = wheel_pos[w] - 5'd1;
					borrow = 1'b0;
				end
			end
		end
	endtask

	// keystream value reduced to the alphabet
	function automatic int key_mod();
		int sum;
		sum = 0;
		for (int w = 0; w < WHEELS; w++)
			sum += int'(wheel_tab[w][wheel_pos[w]]);
		return sum % int'(SYMBOLS);
	endfunction

	task automatic report_miss(input string what, input cipher_out_t want, input cipher_out_t got);
		errors++;
		if (errors <= 10)
			$display("%0t mismatch (%s): expected char %02h bad %0b, got char %02h bad %0b",
				$realtime, what, want.text, want.bad, got.text, got.bad);
	endtask

	always @(posedge clk or negedge arst_n) begin : predict
		cipher_out_t got, want;
		op_t         op;
		logic [7:0]  ch;
		int          wsel, ssel, sym, r;

		if (!arst_n) begin
			for (int w = 0; w < WHEELS; w++) begin
				wheel_pos[w] = '0;
				for (int s = 0; s < SLOTS; s++)
					wheel_tab[w][s] = ENTRY_W'(s);
			end
			cipher_out_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			// output beat against the oldest expectation
			if (m_tvalid && m_tready) begin
				got.text = m_tdata;
				got.bad  = m_tuser;
				if (cipher_out_q.size() == 0) begin
					want = '0;
					report_miss("no beat expected", want, got);
				end else begin
					want = cipher_out_q.pop_front();
					if (got.text !== want.text)
						report_miss("char_out", want, got);
					else if (got.bad !== want.bad)
						report_miss("bad_char", want, got);
				end
			end

			// input beat: update state, queue the result it causes
			if (s_tvalid && s_tready) begin
				op   = op_t'(s_tuser);
				ch   = s_tdata[7:0];
				wsel = int'(s_tdata[9:8]);
				ssel = int'(s_tdata[14:10]);
				case (op)
					OP_WRITE: begin
						if (wsel < WHEELS && ssel < SLOTS)
							wheel_tab[wsel][ssel] = s_tdata[21:15];
					end
					OP_SETPOS: begin
						if (wsel < WHEELS && ssel < SLOTS)
							wheel_pos[wsel] = 5'(ssel);
					end
					default: begin
						if (ch < FIRST_PRINT || ch > LAST_PRINT) begin
							want.text = ch;
							want.bad  = 1'b1;
						end else begin
							sym = int'(ch - FIRST_PRINT);
							if (op == OP_ENC) begin
								r = (sym + key_mod()) % int'(SYMBOLS);
								odometer_fwd();
							end else begin
								odometer_back();
								r = (sym + int'(SYMBOLS) - key_mod()) % int'(SYMBOLS);
							end
							want.text = 8'(r) + FIRST_PRINT;
							want.bad  = 1'b0;
						end
						cipher_out_q.push_back(want);
					end
				endcase
			end
			pending = cipher_out_q.size();
		end
	end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for rotor_sum_char_cipher_top: directed corner beats, then
// random traffic with idling on both sides. Depends on rscc_pkg and rotor_cipher_check.
module tb_top;
	import rscc_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 16;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [1:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [CHAR_W-1:0]   m_tdata;
	logic                m_tuser;

	int   errors;
	int   pending;
	int   quiet_cycles = 0;
	logic calm = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	rotor_sum_char_cipher_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	rotor_cipher_check chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending)
	);

	// output side backpressure
	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= 34);

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// one input beat; called and returns at a falling edge
	task automatic send_beat(input op_t op, input logic [7:0] ch, input logic [1:0] wsel,
			input logic [4:0] ssel, input logic [6:0] val);
		while (!calm && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, val, ssel, wsel, ch};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	initial begin
		int   n, burst, pick;
		op_t  op;
		logic [4:0] ssel;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_ENC;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: full wrap back from all zero, then forward again
		send_beat(OP_DEC, 8'd32, 2'd0, 5'd0, 7'd0);
		send_beat(OP_ENC, 8'd32, 2'd0, 5'd0, 7'd0);
		send_beat(OP_ENC, 8'd126, 2'd0, 5'd0, 7'd0);
		send_beat(OP_DEC, 8'd126, 2'd0, 5'd0, 7'd0);
		// characters just outside the printable range and byte extremes
		send_beat(OP_ENC, 8'd31, 2'd0, 5'd0, 7'd0);
		send_beat(OP_ENC, 8'd127, 2'd0, 5'd0, 7'd0);
		send_beat(OP_DEC, 8'd0, 2'd0, 5'd0, 7'd0);
		send_beat(OP_DEC, 8'd255, 2'd0, 5'd0, 7'd0);
		// table writes at the extremes, two of them out of range
		send_beat(OP_WRITE, 8'd0, 2'd3, 5'd19, 7'd127);
		send_beat(OP_WRITE, 8'd0, 2'd0, 5'd0, 7'd127);
		send_beat(OP_WRITE, 8'hFF, 2'd1, 5'd31, 7'd5);
		send_beat(OP_WRITE, 8'd0, 2'd2, 5'd20, 7'd0);
		// all wheels at the last slot, then wrap forward and back
		send_beat(OP_SETPOS, 8'd0, 2'd3, 5'd19, 7'd0);
		send_beat(OP_SETPOS, 8'd0, 2'd2, 5'd19, 7'd0);
		send_beat(OP_SETPOS, 8'd0, 2'd1, 5'd19, 7'd0);
		send_beat(OP_SETPOS, 8'd0, 2'd0, 5'd19, 7'd0);
		send_beat(OP_ENC, 8'd95, 2'd0, 5'd0, 7'd0);
		send_beat(OP_DEC, 8'd95, 2'd0, 5'd0, 7'd0);
		// out-of-range position sets are ignored
		send_beat(OP_SETPOS, 8'd0, 2'd0, 5'd20, 7'd0);
		send_beat(OP_SETPOS, 8'hFF, 2'd1, 5'd31, 7'h7F);
		send_beat(OP_ENC, 8'd65, 2'd0, 5'd0, 7'd0);
		send_beat(OP_DEC, 8'd97, 2'd0, 5'd0, 7'd0);

		// random traffic, character ops in runs
		n = 0;
		while (n < RANDOM_ITEMS) begin
			calm = (n >= 500 && n < 800);
			pick = $urandom_range(99);
			if (pick < 75) begin
				op = (pick < 45) ? OP_ENC : OP_DEC;
				burst = $urandom_range(8, 1);
				for (int i = 0; i < burst; i++) begin
					if ($urandom_range(99) < 88)
						send_beat(op, 8'($urandom_range(126, 32)), 2'($urandom),
							5'($urandom), 7'($urandom));
					else
						send_beat(op, 8'($urandom_range(255, 0)), 2'($urandom),
							5'($urandom), 7'($urandom));
				end
				n += burst;
			end else begin
				op = (pick < 88) ? OP_WRITE : OP_SETPOS;
				pick = $urandom_range(99);
				if (pick < 10)
					ssel = 5'($urandom_range(31, 20));
				else if (pick < 30 && op == OP_SETPOS)
					ssel = $urandom_range(1) ? 5'd19 : 5'd0;
				else
					ssel = 5'($urandom_range(19, 0));
				send_beat(op, 8'($urandom), 2'($urandom_range(3, 0)), ssel,
					7'($urandom_range(127, 0)));
				n++;
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// drain, then a short settle
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/rscc_pkg.sv
rtl/rscc_ram.sv
rtl/rotor_sum_char_cipher_top.sv
rtl/rscc_checker.sv
test/rotor_cipher_check.sv
test/tb_top.sv
